// ----- rtl/ltr_pkg.sv -----
// shared types and constants for the lexical token recognizer
package ltr_pkg;

    localparam int unsigned KindWidth  = 3;
    localparam int unsigned StateWidth = 3;
    localparam int unsigned CharWidth  = 8;
    localparam int unsigned PosWidth   = 2;

    localparam logic [KindWidth-1:0] KIND_IDENT  = 3'd0;
    localparam logic [KindWidth-1:0] KIND_INT    = 3'd1;
    localparam logic [KindWidth-1:0] KIND_FLOAT  = 3'd2;
    localparam logic [KindWidth-1:0] KIND_CHAR   = 3'd3;
    localparam logic [KindWidth-1:0] KIND_STRING = 3'd4;

    localparam logic [StateWidth-1:0] ST_Q0 = 3'd0;
    localparam logic [StateWidth-1:0] ST_Q1 = 3'd1;
    localparam logic [StateWidth-1:0] ST_Q2 = 3'd2;
    localparam logic [StateWidth-1:0] ST_Q3 = 3'd3;
    localparam logic [StateWidth-1:0] ST_Q4 = 3'd4;

    localparam logic [PosWidth-1:0] POS_FIRST  = 2'd0;
    localparam logic [PosWidth-1:0] POS_SECOND = 2'd1;
    localparam logic [PosWidth-1:0] POS_LATER  = 2'd2;

    localparam logic [CharWidth-1:0] CH_ZERO  = 8'h30;
    localparam logic [CharWidth-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CharWidth-1:0] CH_MINUS = 8'h2D;

    typedef enum logic [3:0] {
        CL_OTHER,
        CL_LETTER,
        CL_DIGIT,
        CL_ZERO,
        CL_UNDER,
        CL_SPACE,
        CL_DOT,
        CL_SEMI,
        CL_BANG,
        CL_SQUOTE,
        CL_DQUOTE,
        CL_PLUS,
        CL_MINUS
    } char_class_t;

    typedef struct packed {
        logic [StateWidth-1:0] state;
        logic                  rejected;
        logic                  accepted;
    } step_result_t;

endpackage

// ----- rtl/ltr_classify.sv -----
// maps a raw byte to its character class, with the integer leading-zero rule
module ltr_classify (
    input  logic [ltr_pkg::CharWidth-1:0] char_code,
    input  logic [ltr_pkg::KindWidth-1:0] token_kind,
    input  logic [ltr_pkg::PosWidth-1:0]  char_position,
    input  logic                          leading_sign_seen,
    output ltr_pkg::char_class_t          char_class
);
    import ltr_pkg::*;

    char_class_t base_class;
    logic        zero_slot;

    always_comb begin
        base_class = CL_OTHER;
        if (char_code inside {[8'h61:8'h7A], [8'h41:8'h5A]}) begin
            base_class = CL_LETTER;
        end else if (char_code inside {[8'h30:8'h39]}) begin
            base_class = CL_DIGIT;
        end else begin
            case (char_code)
                8'h5F:    base_class = CL_UNDER;
                8'h20:    base_class = CL_SPACE;
                8'h2E:    base_class = CL_DOT;
                8'h3B:    base_class = CL_SEMI;
                8'h21:    base_class = CL_BANG;
                8'h27:    base_class = CL_SQUOTE;
                8'h22:    base_class = CL_DQUOTE;
                CH_PLUS:  base_class = CL_PLUS;
                CH_MINUS: base_class = CL_MINUS;
                default:  base_class = CL_OTHER;
            endcase
        end
    end

    // a leading '0', or one right after a leading sign, is its own class in integer mode
    assign zero_slot = (char_position == POS_FIRST) ||
                       ((char_position == POS_SECOND) && leading_sign_seen);

    assign char_class = ((token_kind == KIND_INT) && (char_code == CH_ZERO) && zero_slot)
                        ? CL_ZERO : base_class;

endmodule

// ----- rtl/ltr_step.sv -----
// transition logic of the five automata and the final-state check
module ltr_step (
    input  logic [ltr_pkg::KindWidth-1:0]  token_kind,
    input  logic [ltr_pkg::StateWidth-1:0] state,
    input  logic                           rejected,
    input  ltr_pkg::char_class_t           char_class,
    output ltr_pkg::step_result_t          result
);
    import ltr_pkg::*;

    logic [StateWidth-1:0] ns;
    logic                  ok;
    logic                  final_hit;
    logic [StateWidth-1:0] state_next;
    logic                  rejected_next;

    always_comb begin
        ns = ST_Q0;
        ok = 1'b0;
        case (token_kind)
            KIND_IDENT: begin
                if (state == ST_Q0 && char_class == CL_BANG) begin
                    ns = ST_Q1; ok = 1'b1;
                end else if (state == ST_Q1 && char_class == CL_LETTER) begin
                    ns = ST_Q2; ok = 1'b1;
                end else if (state == ST_Q2 &&
                             char_class inside {CL_LETTER, CL_DIGIT, CL_UNDER}) begin
                    ns = ST_Q2; ok = 1'b1;
                end
            end
            KIND_INT: begin
                if (state == ST_Q0 && char_class == CL_ZERO) begin
                    ns = ST_Q3; ok = 1'b1;
                end else if (state == ST_Q0 && char_class inside {CL_PLUS, CL_MINUS}) begin
                    ns = ST_Q1; ok = 1'b1;
                end else if ((state == ST_Q0 || state == ST_Q1) && char_class == CL_DIGIT) begin
                    ns = ST_Q2; ok = 1'b1;
                end else if (state == ST_Q2 && char_class inside {CL_DIGIT, CL_ZERO}) begin
                    ns = ST_Q2; ok = 1'b1;
                end
            end
            KIND_FLOAT: begin
                if (state == ST_Q0 && char_class inside {CL_PLUS, CL_MINUS}) begin
                    ns = ST_Q1; ok = 1'b1;
                end else if (state <= ST_Q2 && char_class == CL_DIGIT) begin
                    ns = ST_Q2; ok = 1'b1;
                end else if (state == ST_Q2 && char_class == CL_DOT) begin
                    ns = ST_Q3; ok = 1'b1;
                end else if ((state == ST_Q3 || state == ST_Q4) && char_class == CL_DIGIT) begin
                    ns = ST_Q4; ok = 1'b1;
                end
            end
            KIND_CHAR: begin
                if (state == ST_Q0 && char_class == CL_SQUOTE) begin
                    ns = ST_Q1; ok = 1'b1;
                end else if (state == ST_Q1 &&
                             char_class inside {CL_LETTER, CL_DIGIT, CL_UNDER}) begin
                    ns = ST_Q2; ok = 1'b1;
                end else if (state == ST_Q2 && char_class == CL_SQUOTE) begin
                    ns = ST_Q3; ok = 1'b1;
                end
            end
            KIND_STRING: begin
                if (state == ST_Q0 && char_class == CL_DQUOTE) begin
                    ns = ST_Q1; ok = 1'b1;
                end else if ((state == ST_Q1 || state == ST_Q2) && char_class == CL_DQUOTE) begin
                    ns = ST_Q3; ok = 1'b1;
                end else if ((state == ST_Q1 || state == ST_Q2) &&
                             char_class inside {CL_LETTER, CL_DIGIT, CL_UNDER, CL_SPACE,
                                                CL_DOT, CL_SEMI, CL_BANG}) begin
                    ns = ST_Q2; ok = 1'b1;
                end
            end
            default: begin
                ns = ST_Q0;
                ok = 1'b0;
            end
        endcase
    end

    // a dead string keeps its state and ignores further characters
    assign state_next    = (!rejected && ok) ? ns : state;
    assign rejected_next = rejected || !ok;

    always_comb begin
        case (token_kind)
            KIND_IDENT:  final_hit = (state_next == ST_Q2);
            KIND_INT:    final_hit = (state_next == ST_Q2) || (state_next == ST_Q3);
            KIND_FLOAT:  final_hit = (state_next == ST_Q4);
            KIND_CHAR:   final_hit = (state_next == ST_Q3);
            KIND_STRING: final_hit = (state_next == ST_Q3);
            default:     final_hit = 1'b0;
        endcase
    end

    assign result.state    = state_next;
    assign result.rejected = rejected_next;
    assign result.accepted = !rejected_next && final_hit;

endmodule

// ----- rtl/lexical_token_recognizer_core.sv -----
// Lexical token recognizer: checks a character stream against one of five token kinds.
//
// The input stream carries one character per beat: s_tdata is the raw byte and
// s_tlast marks the final character of a string. The kind is set through
// cfg_we / cfg_wdata (0 identifier, 1 integer, 2 float, 3 char constant, 4 string
// constant; other codes reject everything); the user sets the kind only while the block
// is idle, which the block itself does not enforce. Only the last beat of a string
// produces a master-side result beat, accept flag in m_tdata bit 0, in the cycle after it.
// One character per clock while s_tready is high: classification and the automaton
// step sit between the per-string state registers and the result register.
// The result register is the only buffer, so s_tready drops only while a
// result is held and m_tready is low; every beat, last or not, then waits.
// Reset clears the kind to identifier, the string state and the result valid.
// After each last beat the string state returns to its start values.
module lexical_token_recognizer_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [ltr_pkg::KindWidth-1:0] cfg_wdata,   // token_kind
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ltr_pkg::CharWidth-1:0] s_tdata,     // [7:0] char_code
    input  logic                          s_tlast,     // last_char
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata      // [0] accepted, [7:1] zero
);
    import ltr_pkg::*;

    logic [KindWidth-1:0]  token_kind_reg;
    logic [StateWidth-1:0] state_reg;
    logic                  rejected_reg;
    logic [PosWidth-1:0]   pos_reg;
    logic                  sign_reg;
    logic                  m_valid_reg;
    logic                  accepted_reg;

    char_class_t  char_class;
    step_result_t step;
    logic         s_fire;
    logic         is_sign;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign is_sign  = (s_tdata == CH_PLUS) || (s_tdata == CH_MINUS);

    ltr_classify u_classify (
        .char_code         (s_tdata),
        .token_kind        (token_kind_reg),
        .char_position     (pos_reg),
        .leading_sign_seen (sign_reg),
        .char_class        (char_class)
    );

    ltr_step u_step (
        .token_kind (token_kind_reg),
        .state      (state_reg),
        .rejected   (rejected_reg),
        .char_class (char_class),
        .result     (step)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            token_kind_reg <= KIND_IDENT;
            state_reg      <= ST_Q0;
            rejected_reg   <= 1'b0;
            pos_reg        <= POS_FIRST;
            sign_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                token_kind_reg <= cfg_wdata;
            end
            if (s_fire && s_tlast) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (s_fire) begin
                if (s_tlast) begin
                    state_reg    <= ST_Q0;
                    rejected_reg <= 1'b0;
                    pos_reg      <= POS_FIRST;
                    sign_reg     <= 1'b0;
                end else begin
                    state_reg    <= step.state;
                    rejected_reg <= step.rejected;
                    if (pos_reg == POS_FIRST) begin
                        sign_reg <= is_sign;
                    end
                    if (pos_reg != POS_LATER) begin
                        pos_reg <= pos_reg + 2'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && s_tlast) begin
            accepted_reg <= step.accepted;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, accepted_reg};

    a_result_follows_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_tlast |=> m_valid_reg)
        else $error("no result after last beat");

    a_string_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_tlast |=> (state_reg == ST_Q0) && !rejected_reg && (pos_reg == POS_FIRST))
        else $error("string state not cleared after last beat");

    a_pos_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg != 2'd3)
        else $error("character position beyond saturation");

    a_no_accept_past_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_tready |-> !s_tready)
        else $error("beat accepted while result stalled");

endmodule
